// ===== design/jesc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Julia escape-time pixel block.
package jesc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_STEP_X   = 3'd0;
  localparam logic [2:0] REG_STEP_Y   = 3'd1;
  localparam logic [2:0] REG_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y = 3'd3;
  localparam logic [2:0] REG_CONST_RE = 3'd4;
  localparam logic [2:0] REG_CONST_IM = 3'd5;
  localparam logic [2:0] REG_LIMIT    = 3'd6;
  localparam logic [2:0] REG_GAIN     = 3'd7;

  // Escape threshold: |z|^2 > 4 in Q8.56
  localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

  // Bernstein weights scaled by 255 (9, 15 and 8.5 as 17/2)
  localparam logic [16:0] W_RED   = 17'd2295;
  localparam logic [16:0] W_GREEN = 17'd3825;
  localparam logic [16:0] W_BLUE  = 17'd4335;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [23:0] color;
    logic [15:0] iterations;
    logic        inside_res;
  } res_t;

  // Start point handed from front to back
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } pt_t;

  // Settings the back end needs
  typedef struct packed {
    logic signed [31:0] const_real;
    logic signed [31:0] const_imag;
    logic [15:0]        limit;
    logic [15:0]        gain;
  } bcfg_t;

  // Clamp a signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // Q1.16 product, floor
  function automatic logic [16:0] mul16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = a * b;
    return p[32:16];
  endfunction

endpackage

// ===== design/julia_escape_time_pixel.sv =====
// Top level of the Julia escape-time pixel block: configuration registers and wiring.
// One result per pixel. The front maps a pixel into a register and hands the start point
// to a two-entry queue, so new pixels are taken while the back end works. Each iteration
// of the back end passes through S_MUL (the three 32x32 products) and S_ADD (the add,
// clamp and escape test), plus one extra such pass that forms the first point; an
// escaping pixel then runs the bit-serial divide that forms the colour ramp and the
// shading states S_C1 to S_C5. The queue is popped in S_IDLE and the output register
// is loaded from S_DONE. The iteration loop in the back end sets the rate.
module julia_escape_time_pixel (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  jesc_pkg::pix_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output jesc_pkg::res_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import jesc_pkg::*;

  logic [30:0]        step_x, step_y;
  logic signed [31:0] offset_x, offset_y;
  bcfg_t              bcfg;
  logic               push, q_full, q_nonempty, pop;
  pt_t                f_pt, q_pt;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x          <= 31'd4402;
      step_y          <= 31'd4402;
      offset_x        <= 32'sd0;
      offset_y        <= 32'sd0;
      bcfg.const_real <= 32'sd0;
      bcfg.const_imag <= 32'sd0;
      bcfg.limit      <= 16'd100;
      bcfg.gain       <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_X:   step_x          <= cfg_data[30:0];
        REG_STEP_Y:   step_y          <= cfg_data[30:0];
        REG_OFFSET_X: offset_x        <= cfg_data;
        REG_OFFSET_Y: offset_y        <= cfg_data;
        REG_CONST_RE: bcfg.const_real <= cfg_data;
        REG_CONST_IM: bcfg.const_imag <= cfg_data;
        REG_LIMIT:    bcfg.limit      <= cfg_data[15:0];
        REG_GAIN:     bcfg.gain       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  jesc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .step_x(step_x), .step_y(step_y), .offset_x(offset_x), .offset_y(offset_y),
    .push(push), .q_full(q_full), .pt(f_pt)
  );

  jesc_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(f_pt), .full(q_full),
    .pop(pop), .nonempty(q_nonempty), .dout(q_pt)
  );

  jesc_back u_back (
    .clk(clk), .rst(rst), .cfg(bcfg), .q_nonempty(q_nonempty), .q_data(q_pt),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Inside points are always black
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.inside_res |-> out_data.color == 24'd0)
    else $error("inside point with nonzero color");

  // An escaped point stopped short of the limit
  a_escape_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.inside_res |-> out_data.iterations < bcfg.limit)
    else $error("escape count not below limit");

  // Input stalls only when the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with room in queue");

endmodule

// ===== design/jesc_front.sv =====
// Front end: accepts pixel coordinates and maps them to a Q4.28 start point.
module jesc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jesc_pkg::pix_t    in_data,
  input  logic [30:0]       step_x,
  input  logic [30:0]       step_y,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  output logic              push,
  input  logic              q_full,
  output jesc_pkg::pt_t     pt
);
  import jesc_pkg::*;

  logic        vld;
  logic        take;
  logic [40:0] prod_x, prod_y;
  logic signed [65:0] map_x, map_y;

  assign push     = vld && !q_full;
  assign in_stall = vld && q_full;
  assign take     = in_valid && !in_stall;

  // Coordinate times step minus offset, clamped
  assign prod_x = in_data.pixel_x * step_x;
  assign prod_y = in_data.pixel_y * step_y;
  assign map_x  = $signed({25'd0, prod_x}) - 66'(offset_x);
  assign map_y  = $signed({25'd0, prod_y}) - 66'(offset_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (push) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt.re <= sat32(map_x);
      pt.im <= sat32(map_y);
    end
  end

endmodule

// ===== design/jesc_fifo.sv =====
// Two-entry queue of start points between front and back.
module jesc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jesc_pkg::pt_t din,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output jesc_pkg::pt_t dout
);
  import jesc_pkg::*;

  pt_t        mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full     = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign dout     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

// ===== design/jesc_back.sv =====
// Back end: iterates z = z^2 + c, divides for the colour ramp and shades the result.
module jesc_back (
  input  logic            clk,
  input  logic            rst,
  input  jesc_pkg::bcfg_t cfg,
  input  logic            q_nonempty,
  input  jesc_pkg::pt_t   q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output jesc_pkg::res_t  out_data
);
  import jesc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_C1   = 4'd4;
  localparam logic [3:0] S_C2   = 4'd5;
  localparam logic [3:0] S_C3   = 4'd6;
  localparam logic [3:0] S_C4   = 4'd7;
  localparam logic [3:0] S_C5   = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]         st;
  logic signed [31:0] re, im;
  logic signed [63:0] rr, ii, ri;
  logic               chk;
  logic [15:0]        cnt;
  logic [15:0]        rem;
  logic [15:0]        quo;
  logic [4:0]         k;
  logic [16:0]        cr, cg, cb;
  res_t               pend;
  logic               load;

  logic [63:0]        mag;
  logic               escape;
  logic [15:0]        icur;
  logic signed [64:0] dre;
  logic signed [65:0] sre, sim;
  logic               nbit;
  logic [16:0]        trial;
  logic               ge;
  logic [16:0]        t17, u17;
  logic [28:0]        shr, shg, shb;

  assign pop  = (st == S_IDLE) && q_nonempty;
  assign load = (st == S_DONE) && (!out_valid || !out_stall);

  // Escape test on the squares of the current point
  assign mag    = 64'(rr) + 64'(ii);
  assign escape = chk && (mag > ESC_LIMIT);
  assign icur   = chk ? cnt + 16'd1 : cnt;

  // Next point, floored and clamped
  assign dre = 65'(rr) - 65'(ii);
  assign sre = 66'(dre >>> 28) + 66'(cfg.const_real);
  assign sim = 66'(ri >>> 27) + 66'(cfg.const_imag);

  // Restoring divide of cnt * 2^16 by the limit, one bit a cycle
  assign nbit  = (k < 5'd16) ? cnt[4'd15 - k[3:0]] : 1'b0;
  assign trial = {rem, nbit};
  assign ge    = trial >= {1'b0, cfg.limit};

  assign t17 = {1'b0, quo};
  assign u17 = ONE_Q16 - t17;

  // Gain stage
  assign shr = (29'(cr[12:0]) * 29'(cfg.gain)) >> 8;
  assign shg = (29'(cg[12:0]) * 29'(cfg.gain)) >> 8;
  assign shb = (29'(cb[12:0]) * 29'(cfg.gain)) >> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: if (q_nonempty) st <= S_MUL;
        S_MUL:  st <= S_ADD;
        S_ADD: begin
          if (escape) st <= S_DIV;
          else if (icur == cfg.limit) st <= S_DONE;
          else st <= S_MUL;
        end
        S_DIV:  if (k == 5'd31) st <= S_C1;
        S_C1:   st <= S_C2;
        S_C2:   st <= S_C3;
        S_C3:   st <= S_C4;
        S_C4:   st <= S_C5;
        S_C5:   st <= S_DONE;
        S_DONE: if (load) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        re  <= q_data.re;
        im  <= q_data.im;
        chk <= 1'b0;
        cnt <= 16'd0;
      end
      S_MUL: begin
        rr <= re * re;
        ii <= im * im;
        ri <= re * im;
      end
      S_ADD: begin
        rem <= 16'd0;
        quo <= 16'd0;
        k   <= 5'd0;
        if (escape) begin
          pend.inside_res <= 1'b0;
        end else if (icur == cfg.limit) begin
          cnt             <= icur;
          pend.inside_res <= 1'b1;
          pend.color      <= 24'd0;
        end else begin
          cnt <= icur;
          chk <= 1'b1;
          re  <= sat32(sre);
          im  <= sat32(sim);
        end
      end
      S_DIV: begin
        rem <= ge ? 16'(trial - {1'b0, cfg.limit}) : trial[15:0];
        quo <= {quo[14:0], ge};
        k   <= k + 5'd1;
      end
      S_C1: begin
        cr <= mul16(t17, t17);
        cb <= mul16(u17, u17);
      end
      S_C2: begin
        cr <= mul16(cr, t17);
        cg <= mul16(cr, u17);
        cb <= mul16(cb, u17);
      end
      S_C3: begin
        cr <= mul16(cr, u17);
        cg <= mul16(cg, u17);
        cb <= mul16(cb, t17);
      end
      S_C4: begin
        cr <= mul16(W_RED, cr);
        cg <= mul16(W_GREEN, cg);
        cb <= 17'(mul16(W_BLUE, cb) >> 1);
      end
      S_C5: begin
        pend.color[23:16] <= (shr > 29'd255) ? 8'hFF : shr[7:0];
        pend.color[15:8]  <= (shg > 29'd255) ? 8'hFF : shg[7:0];
        pend.color[7:0]   <= (shb > 29'd255) ? 8'hFF : shb[7:0];
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.color      <= pend.color;
      out_data.iterations <= cnt;
      out_data.inside_res <= pend.inside_res;
    end
  end

endmodule
